[src/assert_macros.svh]
// assert_macros.svh: shorthand forms for concurrent assertions.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/npg_pkg.sv]
// npg_pkg: request/result types, codes and the microcode ROM of the
// next permutation generator. No dependencies.
package npg_pkg;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [1:0] ST_PERM      = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;

  localparam logic signed [7:0] SEPARATOR = 8'sd10;

  typedef struct packed {
    logic              action;
    logic signed [7:0] symbol;
    logic              closes_set;
  } request_t;

  typedef struct packed {
    logic signed [7:0] out_symbol;
    logic              run_end;
    logic [1:0]        status;
  } result_t;

  // microprogram steps
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] S_CHK   = 5'd0;
  localparam logic [UPC_W-1:0] S_PRD   = 5'd1;
  localparam logic [UPC_W-1:0] S_PCMP  = 5'd2;
  localparam logic [UPC_W-1:0] S_PZ    = 5'd3;
  localparam logic [UPC_W-1:0] S_SINIT = 5'd4;
  localparam logic [UPC_W-1:0] S_SRD   = 5'd5;
  localparam logic [UPC_W-1:0] S_SCMP  = 5'd6;
  localparam logic [UPC_W-1:0] S_SDEC  = 5'd7;
  localparam logic [UPC_W-1:0] S_SW1   = 5'd8;
  localparam logic [UPC_W-1:0] S_SW2   = 5'd9;
  localparam logic [UPC_W-1:0] S_RCHK  = 5'd10;
  localparam logic [UPC_W-1:0] S_RRD   = 5'd11;
  localparam logic [UPC_W-1:0] S_RW1   = 5'd12;
  localparam logic [UPC_W-1:0] S_RW2   = 5'd13;
  localparam logic [UPC_W-1:0] S_RDONE = 5'd14;
  localparam logic [UPC_W-1:0] S_EINIT = 5'd15;
  localparam logic [UPC_W-1:0] S_EOUT  = 5'd16;
  localparam logic [UPC_W-1:0] S_EEMIT = 5'd17;
  localparam logic [UPC_W-1:0] S_ESEP  = 5'd18;
  localparam logic [UPC_W-1:0] S_XINIT = 5'd19;
  localparam logic [UPC_W-1:0] S_EXS   = 5'd20;
  localparam logic [UPC_W-1:0] S_IDLE  = 5'd21;

  // pointer A operations
  localparam logic [2:0] RA_HOLD = 3'd0;
  localparam logic [2:0] RA_CNT2 = 3'd1;
  localparam logic [2:0] RA_ZERO = 3'd2;
  localparam logic [2:0] RA_INC  = 3'd3;
  localparam logic [2:0] RA_DEC  = 3'd4;

  // pointer B operations
  localparam logic [1:0] RB_HOLD = 2'd0;
  localparam logic [1:0] RB_CNT1 = 2'd1;
  localparam logic [1:0] RB_DEC  = 2'd2;

  // write data select
  localparam logic WS_A_GETS_B = 1'b0;
  localparam logic WS_B_GETS_A = 1'b1;

  // result emission
  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_SYM  = 2'd1;
  localparam logic [1:0] EM_SEP  = 2'd2;
  localparam logic [1:0] EM_EXH  = 2'd3;

  // branch conditions
  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_LT2      = 3'd1;
  localparam logic [2:0] C_GE       = 3'd2;
  localparam logic [2:0] C_RA_ZERO  = 3'd3;
  localparam logic [2:0] C_RA_LT_RB = 3'd4;
  localparam logic [2:0] C_EXH      = 3'd5;
  localparam logic [2:0] C_RA_LAST  = 3'd6;

  typedef struct packed {
    logic             rd;
    logic             we;
    logic             wsel;
    logic [2:0]       ra_op;
    logic [1:0]       rb_op;
    logic             set_exh;
    logic [1:0]       emit;
    logic [2:0]       cond;
    logic [UPC_W-1:0] tgt_t;
    logic [UPC_W-1:0] tgt_f;
  } ctl_t;

  typedef struct packed {
    logic lt2;
    logic ge;
    logic ra_zero;
    logic ra_lt_rb;
    logic exh;
    logic ra_last;
  } flags_t;

  function automatic ctl_t ucode(input logic [UPC_W-1:0] step);
    ctl_t c;
    c = '0;
    c.tgt_t = S_IDLE;
    c.tgt_f = S_IDLE;
    unique case (step)
      S_CHK: begin
        c.ra_op = RA_CNT2; c.rb_op = RB_CNT1;
        c.cond = C_LT2; c.tgt_t = S_EXS; c.tgt_f = S_PRD;
      end
      S_PRD: begin
        c.rd = 1'b1; c.tgt_t = S_PCMP;
      end
      S_PCMP: begin
        c.cond = C_GE; c.tgt_t = S_PZ; c.tgt_f = S_SINIT;
      end
      S_PZ: begin
        c.ra_op = RA_DEC; c.rb_op = RB_DEC;
        c.cond = C_RA_ZERO; c.tgt_t = S_XINIT; c.tgt_f = S_PRD;
      end
      S_SINIT: begin
        c.rb_op = RB_CNT1; c.tgt_t = S_SRD;
      end
      S_SRD: begin
        c.rd = 1'b1; c.tgt_t = S_SCMP;
      end
      S_SCMP: begin
        c.cond = C_GE; c.tgt_t = S_SDEC; c.tgt_f = S_SW1;
      end
      S_SDEC: begin
        c.rb_op = RB_DEC; c.tgt_t = S_SRD;
      end
      S_SW1: begin
        c.we = 1'b1; c.wsel = WS_A_GETS_B; c.tgt_t = S_SW2;
      end
      S_SW2: begin
        c.we = 1'b1; c.wsel = WS_B_GETS_A;
        c.ra_op = RA_INC; c.rb_op = RB_CNT1; c.tgt_t = S_RCHK;
      end
      S_RCHK: begin
        c.cond = C_RA_LT_RB; c.tgt_t = S_RRD; c.tgt_f = S_RDONE;
      end
      S_RRD: begin
        c.rd = 1'b1; c.tgt_t = S_RW1;
      end
      S_RW1: begin
        c.we = 1'b1; c.wsel = WS_A_GETS_B; c.tgt_t = S_RW2;
      end
      S_RW2: begin
        c.we = 1'b1; c.wsel = WS_B_GETS_A;
        c.ra_op = RA_INC; c.rb_op = RB_DEC; c.tgt_t = S_RCHK;
      end
      S_RDONE: begin
        c.cond = C_EXH; c.tgt_t = S_EXS; c.tgt_f = S_EINIT;
      end
      S_EINIT: begin
        c.ra_op = RA_ZERO; c.tgt_t = S_EOUT;
      end
      S_EOUT: begin
        c.rd = 1'b1; c.tgt_t = S_EEMIT;
      end
      S_EEMIT: begin
        c.emit = EM_SYM; c.ra_op = RA_INC;
        c.cond = C_RA_LAST; c.tgt_t = S_ESEP; c.tgt_f = S_EOUT;
      end
      S_ESEP: begin
        c.emit = EM_SEP; c.tgt_t = S_IDLE;
      end
      S_XINIT: begin
        c.ra_op = RA_ZERO; c.rb_op = RB_CNT1; c.set_exh = 1'b1;
        c.tgt_t = S_RCHK;
      end
      S_EXS: begin
        c.emit = EM_EXH; c.tgt_t = S_IDLE;
      end
      S_IDLE: begin
        c.tgt_t = S_IDLE;
      end
      default: begin
        c.tgt_t = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[src/npg_useq.sv]
// npg_useq: step counter and microcode fetch with conditional branching.
// Depends on npg_pkg (ROM, control word and flag types).
module npg_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  npg_pkg::flags_t flags,
  output npg_pkg::ctl_t   ctl,
  output logic            busy
);

  logic [npg_pkg::UPC_W-1:0] upc;
  logic [npg_pkg::UPC_W-1:0] upc_next;
  logic                      taken;

  assign ctl  = npg_pkg::ucode(upc);
  assign busy = (upc != npg_pkg::S_IDLE);

  always_comb begin
    unique case (ctl.cond)
      npg_pkg::C_ALWAYS:   taken = 1'b1;
      npg_pkg::C_LT2:      taken = flags.lt2;
      npg_pkg::C_GE:       taken = flags.ge;
      npg_pkg::C_RA_ZERO:  taken = flags.ra_zero;
      npg_pkg::C_RA_LT_RB: taken = flags.ra_lt_rb;
      npg_pkg::C_EXH:      taken = flags.exh;
      npg_pkg::C_RA_LAST:  taken = flags.ra_last;
      default:             taken = 1'b1;
    endcase
  end

  always_comb begin
    if (upc == npg_pkg::S_IDLE) begin
      upc_next = go ? npg_pkg::S_CHK : npg_pkg::S_IDLE;
    end else begin
      upc_next = taken ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= npg_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

[src/next_permutation_generator.sv]
// next_permutation_generator: symbol store plus microcoded next-permutation
// datapath. Depends on npg_pkg, npg_useq and assert_macros.svh.
// Load: taken when not busy, busy stays low; a dropped load strobes its result the next cycle.
// Advance: busy while the sequencer runs the serial scans over the arrangement RAM; symbols
// strobe one by one, then the separator, or one exhausted result under two symbols or past the
// last arrangement; next request taken when busy drops. Sync reset empties the set, idles sequencer.
`include "assert_macros.svh"

module next_permutation_generator #(
  parameter int MAX_SYMBOLS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  npg_pkg::request_t  request,
  output npg_pkg::result_t   result,
  output logic               result_valid
);

  localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [7:0]    mem [MAX_SYMBOLS];
  logic [CW-1:0] count;
  logic          closed;
  logic          exh;
  logic [IW-1:0] ra;
  logic [IW-1:0] rb;
  logic [IW-1:0] ra_next;
  logic [IW-1:0] rb_next;
  logic [7:0]    da;
  logic [7:0]    db;

  logic [CW:0]   cnt_m1;
  logic [CW:0]   cnt_m2;
  logic [CW-1:0] base;
  logic          full;
  logic          accept;
  logic          load_acc;
  logic          adv_acc;

  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic             emit_any;
  npg_pkg::result_t res_next;
  npg_pkg::ctl_t    ctl;
  npg_pkg::flags_t  flags;

  assign accept   = start && !busy;
  assign load_acc = accept && (request.action == npg_pkg::ACT_LOAD);
  assign adv_acc  = accept && (request.action == npg_pkg::ACT_ADVANCE);

  assign cnt_m1 = {1'b0, count} - (CW+1)'(1);
  assign cnt_m2 = {1'b0, count} - (CW+1)'(2);
  assign base   = closed ? '0 : count;
  assign full   = (base == CW'(MAX_SYMBOLS));

  assign flags.lt2      = ({1'b0, count} < (CW+1)'(2));
  assign flags.ge       = ($signed(da) >= $signed(db));
  assign flags.ra_zero  = (ra == '0);
  assign flags.ra_lt_rb = (ra < rb);
  assign flags.exh      = exh;
  assign flags.ra_last  = ((CW+1)'(ra) == cnt_m1);

  npg_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .go    (adv_acc),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  // pointer updates
  always_comb begin
    unique case (ctl.ra_op)
      npg_pkg::RA_HOLD: ra_next = ra;
      npg_pkg::RA_CNT2: ra_next = IW'(cnt_m2);
      npg_pkg::RA_ZERO: ra_next = '0;
      npg_pkg::RA_INC:  ra_next = ra + IW'(1);
      npg_pkg::RA_DEC:  ra_next = ra - IW'(1);
      default:          ra_next = ra;
    endcase
    unique case (ctl.rb_op)
      npg_pkg::RB_HOLD: rb_next = rb;
      npg_pkg::RB_CNT1: rb_next = IW'(cnt_m1);
      npg_pkg::RB_DEC:  rb_next = rb - IW'(1);
      default:          rb_next = rb;
    endcase
  end

  always_ff @(posedge clk) begin
    ra <= ra_next;
    rb <= rb_next;
  end

  // arrangement RAM: one write port, two registered read ports
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ra;
    mem_wdata = db;
    if (load_acc && !full) begin
      mem_we    = 1'b1;
      mem_addr  = base[IW-1:0];
      mem_wdata = request.symbol;
    end else if (ctl.we) begin
      mem_we    = 1'b1;
      mem_addr  = (ctl.wsel == npg_pkg::WS_B_GETS_A) ? rb : ra;
      mem_wdata = (ctl.wsel == npg_pkg::WS_B_GETS_A) ? da : db;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (ctl.rd) begin
      da <= mem[ra];
      db <= mem[rb];
    end
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      closed <= 1'b0;
      exh    <= 1'b0;
    end else begin
      if (load_acc) begin
        count  <= full ? base : base + CW'(1);
        closed <= request.closes_set;
      end
      if (adv_acc) begin
        exh <= 1'b0;
      end else if (ctl.set_exh) begin
        exh <= 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    emit_any = 1'b1;
    res_next = '0;
    if (load_acc && full) begin
      res_next.run_end = 1'b1;
      res_next.status  = npg_pkg::ST_DROPPED;
    end else begin
      case (ctl.emit)
        npg_pkg::EM_SYM: begin
          res_next.out_symbol = da;
          res_next.status     = npg_pkg::ST_PERM;
        end
        npg_pkg::EM_SEP: begin
          res_next.out_symbol = npg_pkg::SEPARATOR;
          res_next.run_end    = 1'b1;
          res_next.status     = npg_pkg::ST_PERM;
        end
        npg_pkg::EM_EXH: begin
          res_next.run_end = 1'b1;
          res_next.status  = npg_pkg::ST_EXHAUSTED;
        end
        default: begin
          emit_any = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_any;
    end
    if (emit_any) begin
      result <= res_next;
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(MAX_SYMBOLS))
  `ASSERT_IMPLIES(a_read_in_set, clk, rst, ctl.rd, (CW'(ra) < count) && (CW'(rb) < count))
  `ASSERT_NEXT(a_adv_quiet, clk, rst, adv_acc, !result_valid)
  `ASSERT_IMPLIES(a_done_has_result, clk, rst, !$past(rst) && $fell(busy), result_valid)

endmodule

[dv/next_permutation_generator_test.sv]
// next_permutation_generator_test: self-checking testbench for the next permutation
// generator. Predicts every result from a behavioral copy of the symbol set and
// checks each strobed result in order. Depends on npg_pkg and next_permutation_generator.
module next_permutation_generator_test;

  localparam int SET_CAPACITY   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  npg_pkg::request_t request;
  npg_pkg::result_t  result;
  logic              result_valid;

  // predictor state
  logic signed [7:0] perm_symbols [SET_CAPACITY];
  int                perm_count;
  logic              perm_closed;

  npg_pkg::result_t expected_results [$];
  npg_pkg::result_t wanted_result;
  int               mismatch_count;
  int               requests_sent;
  int               burst_left;
  int               idle_cycles;

  next_permutation_generator #(
    .MAX_SYMBOLS(SET_CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result(result),
    .result_valid(result_valid)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void queue_result(logic signed [7:0] sym, logic last, logic [1:0] st);
    npg_pkg::result_t r;
    r.out_symbol = sym;
    r.run_end    = last;
    r.status     = st;
    expected_results = {expected_results, r};
  endfunction

  function automatic void reverse_symbols(int lo, int hi_excl);
    logic signed [7:0] t;
    while (lo + 1 < hi_excl) begin
      t = perm_symbols[lo];
      perm_symbols[lo] = perm_symbols[hi_excl - 1];
      perm_symbols[hi_excl - 1] = t;
      lo++;
      hi_excl--;
    end
  endfunction

  // applies a load, or steps to the next lexicographic permutation of the stored set, signed byte order
  function automatic void apply_request(npg_pkg::request_t r);
    int pivot;
    int succ;
    logic signed [7:0] t;
    if (r.action == npg_pkg::ACT_LOAD) begin
      if (perm_closed) begin
        perm_count  = 0;
        perm_closed = 1'b0;
      end
      if (perm_count < SET_CAPACITY) begin
        perm_symbols[perm_count] = r.symbol;
        perm_count++;
      end else begin
        queue_result(8'sd0, 1'b1, npg_pkg::ST_DROPPED);
      end
      if (r.closes_set) perm_closed = 1'b1;
      return;
    end
    if (perm_count < 2) begin
      queue_result(8'sd0, 1'b1, npg_pkg::ST_EXHAUSTED);
      return;
    end
    pivot = perm_count - 1;
    while (pivot > 0 && perm_symbols[pivot - 1] >= perm_symbols[pivot]) pivot--;
    if (pivot == 0) begin
      reverse_symbols(0, perm_count);
      queue_result(8'sd0, 1'b1, npg_pkg::ST_EXHAUSTED);
      return;
    end
    succ = perm_count - 1;
    while (perm_symbols[succ] <= perm_symbols[pivot - 1]) succ--;
    t = perm_symbols[pivot - 1];
    perm_symbols[pivot - 1] = perm_symbols[succ];
    perm_symbols[succ] = t;
    reverse_symbols(pivot, perm_count);
    for (int i = 0; i < perm_count; i++) begin
      queue_result(perm_symbols[i], 1'b0, npg_pkg::ST_PERM);
    end
    queue_result(npg_pkg::SEPARATOR, 1'b1, npg_pkg::ST_PERM);
  endfunction

  // drives one request, holds it until taken, then predicts its results; random idle gaps between bursts
  task automatic send_request(npg_pkg::request_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      request <= npg_pkg::request_t'(10'($urandom));
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    apply_request(r);
    requests_sent++;
    burst_left--;
  endtask

  task automatic send_load(logic signed [7:0] sym, logic closes);
    npg_pkg::request_t r;
    r.action     = npg_pkg::ACT_LOAD;
    r.symbol     = sym;
    r.closes_set = closes;
    send_request(r);
  endtask

  task automatic send_advance();
    npg_pkg::request_t r;
    r.action     = npg_pkg::ACT_ADVANCE;
    r.symbol     = 8'($urandom);
    r.closes_set = 1'($urandom);
    send_request(r);
  endtask

  task automatic test_directed();
    // empty set, then a single-symbol set
    send_advance();
    send_load(-8'sd128, 1'b1);
    send_advance();
    // new set after a closed one; advance on an open set
    send_load(8'sd127, 1'b0);
    send_load(-8'sd128, 1'b0);
    send_load(8'sd0, 1'b0);
    send_advance();
    send_load(8'sd10, 1'b1);
    send_advance();
    // all equal: no greater arrangement
    send_load(8'sd3, 1'b0);
    send_load(8'sd3, 1'b0);
    send_load(8'sd3, 1'b1);
    send_advance();
    // full set; extra closing load is dropped but closes the set
    for (int i = 0; i < SET_CAPACITY; i++) send_load(8'(7 - i), 1'b0);
    send_load(-8'sd1, 1'b1);
    send_advance();
    send_advance();
    send_load(-8'sd1, 1'b1);
  endtask

  // sets with random content, some overfilled or left open, then advanced a random number of times
  task automatic test_permutation_walks(int target);
    int  n;
    int  steps;
    bit  narrow;
    bit  overfill;
    bit  leave_open;
    logic signed [7:0] sym;
    while (requests_sent < target) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 4) : $urandom_range(1, SET_CAPACITY);
      narrow     = ($urandom_range(0, 2) == 0);
      overfill   = (n == SET_CAPACITY) && ($urandom_range(0, 2) == 0);
      leave_open = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
        sym = narrow ? 8'($urandom_range(0, 3) + 254) : 8'($urandom);
        send_load(sym, (i == n - 1) && !overfill && !leave_open);
      end
      if (overfill) begin
        repeat ($urandom_range(1, 2)) send_load(8'($urandom), 1'b0);
        send_load(8'($urandom), 1'b1);
      end
      steps = $urandom_range(1, (n <= 3) ? 7 : 4);
      repeat (steps) send_advance();
    end
  endtask

  task automatic test_noise(int count);
    repeat (count) send_request(npg_pkg::request_t'(10'($urandom)));
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result sym=%0d end=%0b st=%0d", $time,
                 result.out_symbol, result.run_end, result.status);
        mismatch_count++;
      end else begin
        wanted_result = expected_results.pop_front();
        if (result.out_symbol !== wanted_result.out_symbol ||
            result.run_end !== wanted_result.run_end ||
            result.status !== wanted_result.status) begin
          $display("%0t: mismatch expected sym=%0d end=%0b st=%0d actual sym=%0d end=%0b st=%0d",
                   $time, wanted_result.out_symbol, wanted_result.run_end,
                   wanted_result.status, result.out_symbol, result.run_end, result.status);
          mismatch_count++;
        end
      end
    end
  end

  // nothing taken in either direction for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    perm_count     = 0;
    perm_closed    = 1'b0;
    mismatch_count = 0;
    requests_sent  = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    foreach (perm_symbols[i]) perm_symbols[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_permutation_walks(420);
    test_noise(80);

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
